// File: src/msss_pkg.sv
// shared constants, types and helpers for the multi-stack shared store
`default_nettype none

package msss_pkg;

  localparam int NUM_STACKS = 4;
  localparam int CAPACITY   = 16;

  localparam int DATA_W    = 32;
  localparam int ID_W      = 2;
  localparam int STATUS_W  = 2;
  localparam int ADDR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int PTR_W     = $clog2(CAPACITY + 1);
  localparam int STK_IDX_W = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;

  localparam logic [PTR_W-1:0]    NULL_PTR        = PTR_W'(CAPACITY);
  localparam logic [DATA_W-1:0]   UNDERFLOW_VALUE = 32'h7fff_ffff;

  localparam logic                ACT_PUSH = 1'b0;
  localparam logic                ACT_POP  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // any pointer at or above the capacity counts as null
  function automatic logic [PTR_W-1:0] norm_ptr(input logic [PTR_W-1:0] p);
    return (p >= NULL_PTR) ? NULL_PTR : p;
  endfunction

endpackage

`default_nettype wire

// File: src/multi_stack_shared_store_top.sv
// several lifo stacks sharing one slot store with a linked free list
// usage:
//   input channel (in_valid/in_ready): one word carries in_action (push or pop),
//   in_stack_id and in_value. result channel (out_valid/out_ready): one word per
//   input word with out_popped_value and out_status (ok, overflow, underflow).
//   an input word is read out of the link and data rams at the edge that accepts
//   it and updated in its update cycle, which loads its result into the output
//   register. a new word is taken only once the last one is updated, set by the
//   read-modify-write of the link ram (registered read, then write back).
//   in_ready is high whenever no word is being processed, even while a finished
//   result still waits in the output register; if the receiver stalls, the word
//   in process holds in its update cycle until the output register frees up.
//   reset (rst_n low, synchronous) empties every stack and chains all slots
//   onto the free list; a fill count stands in for the initial link contents,
//   so no clearing pass is needed and words are taken straight after reset.
`default_nettype none

module multi_stack_shared_store_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           in_action,
  input  wire logic [msss_pkg::ID_W-1:0]      in_stack_id,
  input  wire logic signed [msss_pkg::DATA_W-1:0] in_value,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic signed [msss_pkg::DATA_W-1:0]  out_popped_value,
  output logic [msss_pkg::STATUS_W-1:0]       out_status
);

  msss_pkg::state_t state_r, state_nxt;

  logic                              in_fire;
  logic                              exec_fire;

  // words held for the update cycle
  logic                              op_r;
  logic [msss_pkg::STK_IDX_W-1:0]    sid_r;
  logic [msss_pkg::DATA_W-1:0]       value_r;
  logic [msss_pkg::PTR_W-1:0]        slot_r;
  logic                              ok_r;

  // pointer state
  logic [msss_pkg::PTR_W-1:0]        tops_r [msss_pkg::NUM_STACKS];
  logic [msss_pkg::PTR_W-1:0]        free_head_r, free_head_nxt;
  logic [msss_pkg::PTR_W-1:0]        fill_r, fill_nxt;

  logic                              out_valid_r;
  logic [msss_pkg::DATA_W-1:0]       out_value_r;
  logic [msss_pkg::STATUS_W-1:0]     out_status_r;

  logic                              sel_exists;
  logic [msss_pkg::STK_IDX_W-1:0]    sel_idx;
  logic [msss_pkg::PTR_W-1:0]        sel_top;
  logic [msss_pkg::PTR_W-1:0]        sel_slot;

  logic [msss_pkg::PTR_W-1:0]        link_q;
  logic [msss_pkg::PTR_W-1:0]        link_val;
  logic [msss_pkg::PTR_W-1:0]        link_wdata;
  logic                              link_we;
  logic [msss_pkg::DATA_W-1:0]       data_q;
  logic                              data_we;
  logic                              slot_fresh;

  // ---------------- state machine ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      msss_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = msss_pkg::ST_EXEC;
        end
      end
      msss_pkg::ST_EXEC: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = msss_pkg::ST_IDLE;
        end
      end
      default: state_nxt = msss_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    exec_fire = 1'b0;
    case (state_r)
      msss_pkg::ST_IDLE: in_ready  = 1'b1;
      msss_pkg::ST_EXEC: exec_fire = !out_valid_r || out_ready;
      default: begin
        in_ready  = 1'b0;
        exec_fire = 1'b0;
      end
    endcase
  end

  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= msss_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------- accept: pick the slot and start the reads ----------------
  assign sel_exists = 32'(in_stack_id) < 32'(msss_pkg::NUM_STACKS);
  assign sel_idx    = msss_pkg::STK_IDX_W'(in_stack_id);
  assign sel_top    = sel_exists ? tops_r[sel_idx] : msss_pkg::NULL_PTR;
  assign sel_slot   = (in_action == msss_pkg::ACT_PUSH) ? free_head_r : sel_top;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r    <= in_action;
      sid_r   <= sel_idx;
      value_r <= in_value;
      slot_r  <= sel_slot;
      ok_r    <= sel_exists && (sel_slot < msss_pkg::NULL_PTR);
    end
  end

  // ---------------- update cycle ----------------
  // slots never handed out yet read as linked to the next slot, their reset link
  assign slot_fresh = slot_r >= fill_r;
  assign link_val   = slot_fresh ? (slot_r + msss_pkg::PTR_W'(1)) : link_q;
  assign link_we    = exec_fire && ok_r;
  assign link_wdata = (op_r == msss_pkg::ACT_PUSH) ? tops_r[sid_r] : free_head_r;
  assign data_we    = exec_fire && ok_r && (op_r == msss_pkg::ACT_PUSH);

  always_comb begin
    free_head_nxt = free_head_r;
    fill_nxt      = fill_r;
    if (link_we) begin
      if (op_r == msss_pkg::ACT_PUSH) begin
        free_head_nxt = msss_pkg::norm_ptr(link_val);
        if (slot_fresh) begin
          fill_nxt = fill_r + msss_pkg::PTR_W'(1);
        end
      end else begin
        free_head_nxt = slot_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_head_r <= '0;
      fill_r      <= '0;
      for (int i = 0; i < msss_pkg::NUM_STACKS; i++) begin
        tops_r[i] <= msss_pkg::NULL_PTR;
      end
    end else begin
      free_head_r <= free_head_nxt;
      fill_r      <= fill_nxt;
      if (link_we) begin
        if (op_r == msss_pkg::ACT_PUSH) begin
          tops_r[sid_r] <= slot_r;
        end else begin
          tops_r[sid_r] <= msss_pkg::norm_ptr(link_val);
        end
      end
    end
  end

  msss_ram #(
    .WIDTH (msss_pkg::PTR_W),
    .DEPTH (msss_pkg::CAPACITY)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (slot_r[msss_pkg::ADDR_W-1:0]),
    .wdata (link_wdata),
    .re    (in_fire),
    .raddr (sel_slot[msss_pkg::ADDR_W-1:0]),
    .rdata (link_q)
  );

  msss_ram #(
    .WIDTH (msss_pkg::DATA_W),
    .DEPTH (msss_pkg::CAPACITY)
  ) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (slot_r[msss_pkg::ADDR_W-1:0]),
    .wdata (value_r),
    .re    (in_fire),
    .raddr (sel_slot[msss_pkg::ADDR_W-1:0]),
    .rdata (data_q)
  );

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      if (op_r == msss_pkg::ACT_PUSH) begin
        out_value_r  <= '0;
        out_status_r <= ok_r ? msss_pkg::STATUS_OK : msss_pkg::STATUS_OVERFLOW;
      end else begin
        out_value_r  <= ok_r ? data_q : msss_pkg::UNDERFLOW_VALUE;
        out_status_r <= ok_r ? msss_pkg::STATUS_OK : msss_pkg::STATUS_UNDERFLOW;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_popped_value = out_value_r;
  assign out_status       = out_status_r;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= msss_pkg::PTR_W'(msss_pkg::CAPACITY))
    else $error("fill count beyond capacity");

  a_free_head_norm: assert property (@(posedge clk) disable iff (!rst_n)
    free_head_r < msss_pkg::NULL_PTR || free_head_r == msss_pkg::NULL_PTR)
    else $error("free head not normalised");

  a_pop_written_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == msss_pkg::ST_EXEC && ok_r && op_r == msss_pkg::ACT_POP)
      |-> (slot_r < fill_r))
    else $error("pop reads a slot never handed out");

  a_result_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == msss_pkg::ST_EXEC))
    else $error("result without an update cycle");

  a_no_accept_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == msss_pkg::ST_EXEC && !in_ready))
    else $error("word accepted while another is in process");
`endif

endmodule

`default_nettype wire

// File: src/msss_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none

module msss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: tb/multi_stack_shared_store_top_test.sv
// testbench for the multi-stack shared store: self-checking push/pop traffic with stalls
`timescale 1ns / 100ps

class stack_store_scoreboard;
  localparam int CAP = msss_pkg::CAPACITY;
  localparam int PW  = msss_pkg::PTR_W;

  logic [msss_pkg::DATA_W-1:0]   slot_data [CAP];
  logic [PW-1:0]                 slot_link [CAP];
  logic [PW-1:0]                 top_of [msss_pkg::NUM_STACKS];
  logic [PW-1:0]                 free_ptr;
  logic [msss_pkg::DATA_W-1:0]   want_value_q [$];
  logic [msss_pkg::STATUS_W-1:0] want_status_q [$];
  int                            errors;

  function new();
    for (int i = 0; i < CAP; i++) begin
      slot_data[i] = '0;
      slot_link[i] = PW'(i + 1);
    end
    foreach (top_of[s]) top_of[s] = msss_pkg::NULL_PTR;
    free_ptr = '0;
    errors   = 0;
  endfunction

  // apply one accepted word to the shadow stacks and queue its result
  function void note_word(input logic act, input logic [msss_pkg::ID_W-1:0] sid,
                          input logic [msss_pkg::DATA_W-1:0] val);
    logic [PW-1:0]                 slot;
    logic [PW-1:0]                 nxt;
    logic [msss_pkg::DATA_W-1:0]   res;
    logic [msss_pkg::STATUS_W-1:0] st;
    bit                            exists;
    res    = '0;
    st     = msss_pkg::STATUS_OK;
    exists = int'(sid) < msss_pkg::NUM_STACKS;
    if (act == msss_pkg::ACT_PUSH) begin
      if (!exists || free_ptr >= msss_pkg::NULL_PTR) begin
        st = msss_pkg::STATUS_OVERFLOW;
      end else begin
        slot = free_ptr;
        nxt  = slot_link[slot];
        free_ptr = (nxt >= msss_pkg::NULL_PTR) ? msss_pkg::NULL_PTR : nxt;
        slot_link[slot] = top_of[sid];
        top_of[sid]     = slot;
        slot_data[slot] = val;
      end
    end else begin
      if (!exists || top_of[sid] >= msss_pkg::NULL_PTR) begin
        st  = msss_pkg::STATUS_UNDERFLOW;
        res = msss_pkg::UNDERFLOW_VALUE;
      end else begin
        slot = top_of[sid];
        nxt  = slot_link[slot];
        top_of[sid]     = (nxt >= msss_pkg::NULL_PTR) ? msss_pkg::NULL_PTR : nxt;
        slot_link[slot] = free_ptr;
        free_ptr        = slot;
        res             = slot_data[slot];
      end
    end
    want_value_q.push_back(res);
    want_status_q.push_back(st);
  endfunction

  function void check_result(input logic [msss_pkg::DATA_W-1:0] val,
                             input logic [msss_pkg::STATUS_W-1:0] st);
    logic [msss_pkg::DATA_W-1:0]   wv;
    logic [msss_pkg::STATUS_W-1:0] ws;
    if (want_value_q.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected result word: value %h status %0d", val, st);
    end else begin
      wv = want_value_q.pop_front();
      ws = want_status_q.pop_front();
      if (val !== wv || st !== ws) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected value %h status %0d, got value %h status %0d",
                   wv, ws, val, st);
      end
    end
  endfunction

  function int pending();
    return want_value_q.size();
  endfunction
endclass

module multi_stack_shared_store_top_test;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PER_PHASE   = 300;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic                                in_action = msss_pkg::ACT_PUSH;
  logic [msss_pkg::ID_W-1:0]           in_stack_id = '0;
  logic signed [msss_pkg::DATA_W-1:0]  in_value = '0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic signed [msss_pkg::DATA_W-1:0]  out_popped_value;
  logic [msss_pkg::STATUS_W-1:0]       out_status;

  stack_store_scoreboard      sb = new();
  int                         in_idle_pct = 0;
  int                         out_stall_pct = 0;
  logic                       hold_off = 1'b0;
  int                         cycle_cnt = 0;
  // occupancy seen by the stimulus generator, updated on acceptance
  int                         depth [msss_pkg::NUM_STACKS];
  int                         fill_count = 0;
  logic [msss_pkg::DATA_W-1:0] corner_values [4] = '{32'h8000_0000, 32'h7fff_ffff,
                                                     32'h0000_0000, 32'hffff_ffff};

  multi_stack_shared_store_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_stack_id      (in_stack_id),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_popped_value (out_popped_value),
    .out_status       (out_status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      sb.note_word(in_action, in_stack_id, in_value);
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_popped_value, out_status);
  end

  always @(posedge clk) begin
    if (hold_off)
      out_ready <= 1'b0;
    else
      out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("TB_ERROR");
    $finish;
  end

  task automatic send_word(input logic act, input logic [msss_pkg::ID_W-1:0] sid,
                           input logic [msss_pkg::DATA_W-1:0] val);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_action   <= act;
    in_stack_id <= sid;
    in_value    <= val;
    do @(posedge clk); while (!in_ready);
    if (act == msss_pkg::ACT_PUSH && fill_count < msss_pkg::CAPACITY) begin
      depth[sid]++;
      fill_count++;
    end else if (act == msss_pkg::ACT_POP && depth[sid] > 0) begin
      depth[sid]--;
      fill_count--;
    end
  endtask

  // mostly fill/drain sweeps so the free list gets shuffled, with some noise
  task automatic random_words(input int count);
    int                          mode;
    int                          push_pct;
    logic                        act;
    logic [msss_pkg::ID_W-1:0]   sid;
    logic [msss_pkg::DATA_W-1:0] val;
    bit                          noise;
    mode = 0;
    for (int n = 0; n < count; n++) begin
      if (fill_count == msss_pkg::CAPACITY) mode = 1;
      else if (fill_count == 0) mode = 0;
      else if ($urandom_range(31) == 0) mode = $urandom_range(2);
      push_pct = (mode == 0) ? 75 : (mode == 1) ? 25 : 50;
      noise = ($urandom_range(9) == 0);
      if (noise)
        act = 1'($urandom_range(1));
      else
        act = ($urandom_range(99) < push_pct) ? msss_pkg::ACT_PUSH : msss_pkg::ACT_POP;
      sid = msss_pkg::ID_W'($urandom_range(msss_pkg::NUM_STACKS - 1));
      if (act == msss_pkg::ACT_POP && !noise) begin
        for (int t = 0; t < 4 && depth[sid] == 0; t++)
          sid = msss_pkg::ID_W'($urandom_range(msss_pkg::NUM_STACKS - 1));
      end
      val = ($urandom_range(7) == 0) ? corner_values[$urandom_range(3)] : $urandom;
      send_word(act, sid, val);
    end
  endtask

  task automatic drain_wait();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    foreach (depth[s]) depth[s] = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty stacks, corner values, fill to overflow, then unwind
    for (int s = 0; s < msss_pkg::NUM_STACKS; s++)
      send_word(msss_pkg::ACT_POP, msss_pkg::ID_W'(s), $urandom);
    for (int i = 0; i < msss_pkg::CAPACITY; i++)
      send_word(msss_pkg::ACT_PUSH, msss_pkg::ID_W'(i % msss_pkg::NUM_STACKS),
                (i < 4) ? corner_values[i] : $urandom);
    send_word(msss_pkg::ACT_PUSH, msss_pkg::ID_W'(2), $urandom);
    send_word(msss_pkg::ACT_POP, msss_pkg::ID_W'(3), $urandom);
    send_word(msss_pkg::ACT_POP, msss_pkg::ID_W'(0), $urandom);
    send_word(msss_pkg::ACT_POP, msss_pkg::ID_W'(1), $urandom);
    send_word(msss_pkg::ACT_POP, msss_pkg::ID_W'(2), $urandom);

    random_words(PER_PHASE);

    in_idle_pct = 46;
    random_words(PER_PHASE);

    in_idle_pct = 0;
    out_stall_pct <= 46;
    random_words(PER_PHASE);

    // receiver holds off for a long stretch while words keep coming
    out_stall_pct <= 0;
    fork
      begin
        hold_off <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off <= 1'b0;
      end
    join_none
    random_words(40);

    in_idle_pct = 6;
    out_stall_pct <= 6;
    random_words(PER_PHASE);

    in_valid <= 1'b0;
    drain_wait();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// File: multi_stack_shared_store_top.f
src/msss_pkg.sv
src/msss_ram.sv
src/multi_stack_shared_store_top.sv
tb/multi_stack_shared_store_top_test.sv
